@@ hw/rtl/sdt_pkg.sv @@
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types, codes and sizes of the socket demultiplexing table.
// ----------------------------------------------------------------------------
`default_nettype none

package sdt_pkg;

    localparam int SDT_TABLE_ENTRIES = 16;
    localparam int SDT_ID_RETRIES    = 17;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int ID_W     = 16;
    localparam int CSLOT_W  = 4;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;

    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
    localparam logic [OP_W-1:0] OP_UDP   = 2'd2;
    localparam logic [OP_W-1:0] OP_ICMP  = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOID = 3'd2;
    localparam logic [STATUS_W-1:0] STS_DUP  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_DROP = 3'd4;

    localparam logic [ID_W-1:0] MAX_ID = 16'hFFFF;

    typedef struct packed {
        logic [ADDR_W-1:0] remote_addr;
        logic [PORT_W-1:0] local_port;
        logic [PORT_W-1:0] remote_port;
        logic              icmp;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic tuple_hit;
        logic id_taken;
        logic echo_hit;
    } match_t;

endpackage

`default_nettype wire

@@ hw/rtl/sdt_entry_mem.sv @@
// ----------------------------------------------------------------------------
// sdt_entry_mem
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_entry_mem
    import sdt_pkg::*;
#(
    parameter int DEPTH = SDT_TABLE_ENTRIES,
    parameter int IDX_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire entry_t           wr_data,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data <= mem[rd_idx];
    end

endmodule

`default_nettype wire

@@ hw/rtl/sdt_match_unit.sv @@
// ----------------------------------------------------------------------------
// sdt_match_unit
// Shared compare unit: one stored slot against the lookup key.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_match_unit
    import sdt_pkg::*;
(
    input  wire entry_t entry,
    input  wire entry_t key,
    output match_t      hit
);

    logic addr_eq;
    logic id_eq;

    assign addr_eq = (entry.remote_addr == key.remote_addr);
    assign id_eq   = entry.icmp && (entry.id == key.id);

    assign hit.tuple_hit = addr_eq && (entry.local_port == key.local_port)
                           && (entry.remote_port == key.remote_port);
    assign hit.id_taken  = id_eq;
    assign hit.echo_hit  = id_eq && addr_eq;

endmodule

`default_nettype wire

@@ hw/rtl/socket_demux_table.sv @@
// ----------------------------------------------------------------------------
// socket_demux_table
// Bounded socket table with open, close and udp / icmp delivery lookups.
// ----------------------------------------------------------------------------
// delivery and open: one pass of the compare unit over the slot store, one slot read per
// cycle, then the evaluate state and the output state
// icmp open: each further id try adds another pass and evaluate, ID_RETRIES tries max
// close: frees the slot at accept and goes straight to the output state, no pass
// one request at a time, taken in idle only; output state holds while a result beat waits
// reset: all slots free and the id counter at 1 at once, no clearing pass
`default_nettype none

module socket_demux_table
    import sdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = SDT_TABLE_ENTRIES,
    parameter int ID_RETRIES    = SDT_ID_RETRIES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // remote_addr, local_port, remote_port, echo_id, close_slot, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode, is_icmp
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // status, slot, assigned_id, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int TRY_W = $clog2(ID_RETRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [ID_W-1:0]          next_id_reg;
    logic [ID_W-1:0]          next_id_next;

    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] ra_reg;
    logic [PORT_W-1:0] lp_reg;
    logic [PORT_W-1:0] rp_reg;
    logic              icmp_reg;
    logic [ID_W-1:0]   eid_reg;

    logic [CNT_W-1:0]  issue_cnt_reg;
    logic              cmp_live_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [TRY_W-1:0]  try_cnt_reg;
    logic [TRY_W-1:0]  try_inc;

    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic              id_hit_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [ID_W-1:0]     res_id_reg;

    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic              s_accept;
    logic              issue_done;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    entry_t            wr_data;
    entry_t            rd_data;
    entry_t            key;
    match_t            hit;
    logic              cur_valid;
    logic              cur_match;
    logic              cur_id_hit;

    logic [OP_W-1:0]    in_opcode;
    logic [ADDR_W-1:0]  in_remote_addr;
    logic [PORT_W-1:0]  in_local_port;
    logic [PORT_W-1:0]  in_remote_port;
    logic               in_is_icmp;
    logic [ID_W-1:0]    in_echo_id;
    logic [CSLOT_W-1:0] in_close_slot;

    assign in_remote_addr = s_axis_tdata[31:0];
    assign in_local_port  = s_axis_tdata[47:32];
    assign in_remote_port = s_axis_tdata[63:48];
    assign in_echo_id     = s_axis_tdata[79:64];
    assign in_close_slot  = s_axis_tdata[83:80];
    assign in_opcode      = s_axis_tuser[1:0];
    assign in_is_icmp     = s_axis_tuser[2];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign issue_done = (issue_cnt_reg == CNT_W'(TABLE_ENTRIES));
    assign rd_idx     = issue_done ? '0 : issue_cnt_reg[IDX_W-1:0];
    assign try_inc    = try_cnt_reg + TRY_W'(1);

    // counter runs 1..65535, never 0
    assign next_id_next = (next_id_reg >= MAX_ID || next_id_reg == '0) ? ID_W'(1)
                                                                       : next_id_reg + ID_W'(1);

    assign key.remote_addr = ra_reg;
    assign key.local_port  = lp_reg;
    assign key.remote_port = rp_reg;
    assign key.icmp        = 1'b1;
    assign key.id          = (op_reg == OP_ICMP) ? eid_reg : next_id_reg;

    assign wr_data.remote_addr = ra_reg;
    assign wr_data.local_port  = lp_reg;
    assign wr_data.remote_port = rp_reg;
    assign wr_data.icmp        = icmp_reg;
    assign wr_data.id          = icmp_reg ? next_id_reg : '0;

    assign wr_en = (state_reg == S_EVAL) && (op_reg == OP_OPEN) && free_found_reg
                   && !(icmp_reg && id_hit_reg) && !match_found_reg;

    sdt_entry_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (free_idx_reg),
        .wr_data (wr_data),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    sdt_match_unit u_match (
        .entry (rd_data),
        .key   (key),
        .hit   (hit)
    );

    assign cur_valid  = valid_reg[cmp_idx_reg];
    assign cur_match  = cur_valid && ((op_reg == OP_ICMP) ? hit.echo_hit : hit.tuple_hit);
    assign cur_id_hit = cur_valid && hit.id_taken;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            next_id_reg  <= ID_W'(1);
            cmp_live_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // the output state loads the result beat itself
            if (m_valid_reg && m_axis_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        op_reg         <= in_opcode;
                        ra_reg         <= in_remote_addr;
                        lp_reg         <= in_local_port;
                        rp_reg         <= in_remote_port;
                        icmp_reg       <= in_is_icmp;
                        eid_reg        <= in_echo_id;
                        try_cnt_reg    <= '0;
                        issue_cnt_reg  <= '0;
                        cmp_live_reg   <= 1'b0;
                        free_found_reg <= 1'b0;
                        match_found_reg <= 1'b0;
                        id_hit_reg     <= 1'b0;
                        res_status_reg <= STS_OK;
                        res_slot_reg   <= '0;
                        res_id_reg     <= '0;
                        if (in_opcode == OP_CLOSE) begin
                            if (int'(in_close_slot) < TABLE_ENTRIES) begin
                                valid_reg[IDX_W'(in_close_slot)] <= 1'b0;
                            end
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    // read issue runs ahead of the compare, which sees the registered read data
                    if (!issue_done) begin
                        issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                        cmp_idx_reg   <= rd_idx;
                        cmp_live_reg  <= 1'b1;
                    end else begin
                        cmp_live_reg  <= 1'b0;
                    end
                    if (cmp_live_reg) begin
                        if (!cur_valid && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= cmp_idx_reg;
                        end
                        if (cur_match && !match_found_reg) begin
                            match_found_reg <= 1'b1;
                            match_idx_reg   <= cmp_idx_reg;
                        end
                        if (cur_id_hit) begin
                            id_hit_reg <= 1'b1;
                        end
                        if (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                            state_reg <= S_EVAL;
                        end
                    end
                end

                S_EVAL: begin
                    unique case (op_reg) inside
                        OP_OPEN: begin
                            if (!free_found_reg) begin
                                res_status_reg <= STS_FULL;
                                state_reg      <= S_OUT;
                            end else if (icmp_reg && id_hit_reg) begin
                                next_id_reg <= next_id_next;
                                if (try_inc == TRY_W'(ID_RETRIES)) begin
                                    res_status_reg <= STS_NOID;
                                    state_reg      <= S_OUT;
                                end else begin
                                    // another pass with the advanced candidate
                                    try_cnt_reg     <= try_inc;
                                    issue_cnt_reg   <= '0;
                                    cmp_live_reg    <= 1'b0;
                                    free_found_reg  <= 1'b0;
                                    match_found_reg <= 1'b0;
                                    id_hit_reg      <= 1'b0;
                                    state_reg       <= S_SCAN;
                                end
                            end else begin
                                state_reg <= S_OUT;
                                if (icmp_reg) begin
                                    next_id_reg <= next_id_next;
                                end
                                if (match_found_reg) begin
                                    res_status_reg <= STS_DUP;
                                end else begin
                                    valid_reg[free_idx_reg] <= 1'b1;
                                    res_slot_reg <= SLOT_W'(free_idx_reg);
                                    res_id_reg   <= icmp_reg ? next_id_reg : '0;
                                end
                            end
                        end
                        OP_UDP, OP_ICMP: begin
                            state_reg <= S_OUT;
                            if (match_found_reg) begin
                                res_slot_reg <= SLOT_W'(match_idx_reg);
                            end else begin
                                res_status_reg <= STS_DROP;
                            end
                        end
                        default: begin
                            state_reg      <= S_OUT;
                            res_status_reg <= STS_OK;
                        end
                    endcase
                end

                S_OUT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {1'b0, res_id_reg, res_slot_reg, res_status_reg};
                        state_reg   <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
